### sv/mlr_pkg.sv
// Shared types for the midpoint line rasterizer.
// Request and pixel payload structs; no dependencies.
`default_nettype none

package mlr_pkg;

	localparam int unsigned PIX_COORD_W = 6;

	typedef struct packed {
		logic                   req_type;
		logic [PIX_COORD_W-1:0] x_coord;
		logic [PIX_COORD_W-1:0] y_coord;
	} mlr_req_t;

	typedef struct packed {
		logic [PIX_COORD_W-1:0] pix_x;
		logic [PIX_COORD_W-1:0] pix_y;
		logic                   last_pixel;
	} mlr_pix_t;

	localparam logic REQ_MOVE = 1'b0;
	localparam logic REQ_LINE = 1'b1;

endpackage

`default_nettype wire

### sv/midpoint_line_rasterizer.sv
// Midpoint line rasterizer top level: setup sequencer and one shared decision adder.
// Depends on mlr_pkg for the request and pixel structs.
// Move request: no pixels. Line request: an accept state (IDLE), a setup state (SETUP),
// then one pixel per cycle over the major-axis span (0..2**COORD_BITS-1 pixels),
// each cycle of the run gated by the pixel output register draining.
// Reset: arst_n clears the sequencer, output valid and the current point to (0,0).
`default_nettype none

module midpoint_line_rasterizer
	import mlr_pkg::*;
#(
	parameter int unsigned COORD_BITS = 6
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_ready,
	input  wire mlr_req_t req,
	output logic          pix_valid,
	input  wire logic     pix_ready,
	output mlr_pix_t      pix
);

	localparam int unsigned DW = COORD_BITS + 1;
	localparam int unsigned EW = COORD_BITS + 4;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SETUP = 2'd1;
	localparam logic [1:0] ST_RUN   = 2'd2;

	localparam logic [1:0] CND_NONE = 2'd0;
	localparam logic [1:0] CND_GE   = 2'd1;
	localparam logic [1:0] CND_LT   = 2'd2;
	localparam logic [1:0] CND_GT   = 2'd3;

	logic [1:0]            state_q;
	logic [COORD_BITS-1:0] cur_x_q, cur_y_q, tgt_x_q, tgt_y_q;
	logic [COORD_BITS-1:0] px_q, py_q, cnt_q;
	logic signed [EW-1:0]  d_q, inc_a_q, inc_b_q;
	logic [1:0]            cnd_q;
	logic                  ymaj_q, ydown_q;
	mlr_pix_t              pix_q;
	logic                  pix_valid_q;

	// setup arithmetic
	logic signed [DW-1:0]  ax, ay, bx, by, dx, dy, adx, ady, dxo, dyo;
	logic signed [EW-1:0]  ex, ey, ex2, ey2, d0, inc_a, inc_b;
	logic                  same, vert, steep, c_sp, c_sh, c_shn, c_snn, swap;
	logic [1:0]            cnd;
	logic [COORD_BITS-1:0] len, sx, sy;

	always_comb begin
		ax = signed'({1'b0, cur_x_q});
		ay = signed'({1'b0, cur_y_q});
		bx = signed'({1'b0, tgt_x_q});
		by = signed'({1'b0, tgt_y_q});
		dx = bx - ax;
		dy = by - ay;
		adx = dx[DW-1] ? -dx : dx;
		ady = dy[DW-1] ? -dy : dy;
		same = (dx > 0 && dy >= 0) || (dx < 0 && dy <= 0);
		vert = (dx == 0);
		steep = ady > adx;
		c_sp  = !vert && same && steep;
		c_sh  = !vert && same && !steep;
		c_shn = !vert && !same && !steep;
		c_snn = !vert && !same && steep;
		if (vert || c_sp) begin
			swap = ay > by;
		end else if (c_snn) begin
			swap = ay < by;
		end else begin
			swap = ax > bx;
		end
		dxo = swap ? -dx : dx;
		dyo = swap ? -dy : dy;
		ex = EW'(dxo);
		ey = EW'(dyo);
		ex2 = ex <<< 1;
		ey2 = ey <<< 1;
		d0 = '0;
		inc_a = '0;
		inc_b = '0;
		cnd = CND_NONE;
		if (c_sp) begin
			d0 = ex2 - ey;
			inc_a = ex2 - ey2;
			inc_b = ex2;
			cnd = CND_GE;
		end else if (c_sh) begin
			d0 = ex - ey2;
			inc_a = ex2 - ey2;
			inc_b = -ey2;
			cnd = CND_LT;
		end else if (c_shn) begin
			d0 = -ex - ey2;
			inc_a = -(ex2 + ey2);
			inc_b = -ey2;
			cnd = CND_GT;
		end else if (c_snn) begin
			d0 = -ex2 - ey;
			inc_a = -(ex2 + ey2);
			inc_b = -ex2;
			cnd = CND_LT;
		end
		len = (vert || steep) ? ady[COORD_BITS-1:0] : adx[COORD_BITS-1:0];
		sx = swap ? tgt_x_q : cur_x_q;
		sy = swap ? tgt_y_q : cur_y_q;
	end

	// shared decision unit
	logic                  take, step, last;
	logic signed [EW-1:0]  d_nxt;
	logic [COORD_BITS-1:0] y_step;

	always_comb begin
		case (cnd_q)
			CND_GE:  take = !d_q[EW-1];
			CND_LT:  take = d_q[EW-1];
			CND_GT:  take = !d_q[EW-1] && (d_q != '0);
			default: take = 1'b0;
		endcase
		d_nxt = d_q + (take ? inc_a_q : inc_b_q);
		y_step = ydown_q ? py_q - COORD_BITS'(1) : py_q + COORD_BITS'(1);
		step = (state_q == ST_RUN) && (!pix_valid_q || pix_ready);
		last = (cnt_q == COORD_BITS'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pix_valid_q <= 1'b0;
			cur_x_q <= '0;
			cur_y_q <= '0;
		end else begin
			pix_valid_q <= step || (pix_valid_q && !pix_ready);
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						if (req.req_type == REQ_MOVE) begin
							cur_x_q <= req.x_coord[COORD_BITS-1:0];
							cur_y_q <= req.y_coord[COORD_BITS-1:0];
						end else begin
							state_q <= ST_SETUP;
						end
					end
				end
				ST_SETUP: begin
					cur_x_q <= tgt_x_q;
					cur_y_q <= tgt_y_q;
					state_q <= (len == '0) ? ST_IDLE : ST_RUN;
				end
				ST_RUN: begin
					if (step && last) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_valid) begin
			tgt_x_q <= req.x_coord[COORD_BITS-1:0];
			tgt_y_q <= req.y_coord[COORD_BITS-1:0];
		end
		if (state_q == ST_SETUP) begin
			px_q <= sx;
			py_q <= sy;
			cnt_q <= len;
			d_q <= d0;
			inc_a_q <= inc_a;
			inc_b_q <= inc_b;
			cnd_q <= cnd;
			ymaj_q <= vert || steep;
			ydown_q <= c_shn || c_snn;
		end
		if (step) begin
			pix_q.pix_x <= PIX_COORD_W'(px_q);
			pix_q.pix_y <= PIX_COORD_W'(py_q);
			pix_q.last_pixel <= last;
			cnt_q <= cnt_q - COORD_BITS'(1);
			d_q <= d_nxt;
			if (ymaj_q) begin
				py_q <= y_step;
				if (take) begin
					px_q <= px_q + COORD_BITS'(1);
				end
			end else begin
				px_q <= px_q + COORD_BITS'(1);
				if (take) begin
					py_q <= y_step;
				end
			end
		end
	end

	assign req_ready = (state_q == ST_IDLE);
	assign pix_valid = pix_valid_q;
	assign pix = pix_q;

endmodule

`default_nettype wire

### sv/mlr_checker.sv
// Port-level checker for midpoint_line_rasterizer, bound to the top level.
// Depends on mlr_pkg for the request and pixel structs.
`default_nettype none

module mlr_checker
	import mlr_pkg::*;
(
	input wire logic     clk,
	input wire logic     arst_n,
	input wire logic     req_valid,
	input wire logic     req_ready,
	input wire mlr_req_t req,
	input wire logic     pix_valid,
	input wire logic     pix_ready,
	input wire mlr_pix_t pix
);

	// held pixel must not change until taken
	a_pix_hold: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_ready |=> pix_valid && $stable(pix))
		else $error("pixel changed while stalled");

	// a move request never starts a run
	a_move_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req.req_type == REQ_MOVE |=> !$rose(pix_valid))
		else $error("pixel after move request");

	// busy only after a line request
	a_busy_line: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(req_ready) |-> $past(req_valid && req.req_type == REQ_LINE))
		else $error("busy without line request");

	// a run still in progress keeps requests out
	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix.last_pixel |-> !req_ready)
		else $error("ready during run");

endmodule

bind midpoint_line_rasterizer mlr_checker u_mlr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_ready (req_ready),
	.req       (req),
	.pix_valid (pix_valid),
	.pix_ready (pix_ready),
	.pix       (pix)
);

`default_nettype wire
